@@ hdl/url_component_splitter_core_defines.svh @@
// Assertion macros shared by the URL component splitter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef URL_COMPONENT_SPLITTER_CORE_DEFINES_SVH
`define URL_COMPONENT_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ucs_pkg.sv @@
// Types and constants of the URL component splitter.
// No dependencies; used by the result channel interface, parser, result queue and top level.
package ucs_pkg;

  localparam int unsigned START_W    = 12;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned MAX_RES    = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = 3;
  localparam int unsigned FILL_W     = 4;

  // Characters the grammar looks at
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  typedef enum logic [4:0] {
    ST_BEGIN, ST_SCHEME, ST_AFTER_COLON, ST_SL1, ST_SL2, ST_UH, ST_PP,
    ST_H1, ST_H2, ST_BOPEN, ST_V6, ST_BCLOSE, ST_PORT, ST_PATH, ST_QUERY,
    ST_FRAG, ST_ERR
  } ucs_mode_e;

  typedef enum logic [3:0] {
    K_SCHEME, K_USER, K_PWD, K_HOST, K_PORT, K_PATH, K_QUERY, K_FRAG, K_DONE
  } ucs_kind_e;

  typedef struct packed {
    ucs_kind_e           kind;
    logic [START_W-1:0]  start_pos;
    logic [LEN_W-1:0]    span_len;
    logic [PORT_W-1:0]   port_num;
    logic                ok;
    logic                final_res;
  } ucs_res_t;

  // Results one byte produces, lowest slot first
  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    ucs_res_t [MAX_RES-1:0]      res;
  } ucs_batch_t;

  typedef struct packed {
    logic not_empty;
    logic room;
  } ucs_fifo_stat_t;

endpackage

@@ hdl/ucs_if.sv @@
// Request and result channel interfaces of the URL component splitter.
// Depends on ucs_pkg for field widths.
interface ucs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_byte;

  modport source (output valid, output ch, output last_byte, input ready);
  modport sink   (input valid, input ch, input last_byte, output ready);
endinterface

interface ucs_res_if;
  import ucs_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [START_W-1:0] start_pos;
  logic [LEN_W-1:0]   span_len;
  logic [PORT_W-1:0]  port_num;
  logic               ok;
  logic               final_res;

  modport source (output valid, output kind, output start_pos, output span_len,
                  output port_num, output ok, output final_res, input ready);
  modport sink   (input valid, input kind, input start_pos, input span_len,
                  input port_num, input ok, input final_res, output ready);
endinterface

@@ hdl/url_component_splitter_core.sv @@
// URL component splitter top level: request register, parser, result queue.
// Depends on ucs_pkg, ucs_if, ucs_parser, ucs_res_fifo and the defines header.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    ch, last_byte
//   res_o    out  valid/ready    kind, start_pos, span_len, port_num, ok, final_res
//
// One byte per cycle enters the request register while the queue has room, and the
// parser steps on the held byte; the queue registers its results for res_o.
// A byte yields zero to four results; res_o hands out one per cycle while the sink
// is ready, so the sustained rate is one byte per cycle if each yields at most one.
// The register holds its byte while the 8-entry queue has fewer than 4 free slots.
// Reset is asynchronous, active low, and returns the parser to its start state.
module url_component_splitter_core #(
  parameter int unsigned MAX_URL_LEN = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  ucs_byte_if.sink   req_i,
  ucs_res_if.source  res_o
);
  import ucs_pkg::*;
  `include "url_component_splitter_core_defines.svh"

  logic           in_v_q;
  logic [7:0]     ch_q;
  logic           last_q;
  logic           take;
  ucs_batch_t     batch;
  ucs_res_t       head;
  ucs_fifo_stat_t stat;

  // Hand the held byte to the parser when the queue can take its results
  assign take        = in_v_q && stat.room;
  assign req_i.ready = !in_v_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (req_i.ready) begin
      in_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      ch_q   <= req_i.ch;
      last_q <= req_i.last_byte;
    end
  end

  ucs_parser #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .ch_i        (ch_q),
    .last_byte_i (last_q),
    .batch_o     (batch)
  );

  ucs_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .pop_i   (res_o.valid && res_o.ready),
    .head_o  (head),
    .stat_o  (stat)
  );

  // Drive the result channel from the queue head
  assign res_o.valid     = stat.not_empty;
  assign res_o.kind      = head.kind;
  assign res_o.start_pos = head.start_pos;
  assign res_o.span_len  = head.span_len;
  assign res_o.port_num  = head.port_num;
  assign res_o.ok        = head.ok;
  assign res_o.final_res = head.final_res;

  `UCS_ASSERT_IMPL(a_ok_only_done, clk_i, rst_ni,
                   res_o.valid && (res_o.kind != K_DONE), !res_o.ok && !res_o.final_res,
                   "ok or final set on a non-done result")
  `UCS_ASSERT_IMPL(a_last_closes, clk_i, rst_ni, take && last_q, batch.cnt != '0,
                   "last byte produced no done result")
  `UCS_ASSERT_NEXT(a_drain, clk_i, rst_ni, in_v_q && stat.room && !req_i.valid, !in_v_q,
                   "held byte not consumed with queue room")
  `UCS_ASSERT_NEXT(a_hold_full, clk_i, rst_ni, in_v_q && !stat.room,
                   in_v_q && $stable(ch_q), "held byte lost while queue full")

endmodule

@@ hdl/ucs_parser.sv @@
// Per-byte URL grammar: parse state registers and the step logic that
// turns one byte into up to four results. Depends on ucs_pkg.
module ucs_parser #(
  parameter int unsigned MAX_URL_LEN = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  input  logic                last_byte_i,
  output ucs_pkg::ucs_batch_t batch_o
);
  import ucs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_URL_LEN + 1);
  typedef logic [PW-1:0] pos_t;
  localparam pos_t PosMax = pos_t'(MAX_URL_LEN);
  localparam pos_t PosOne = pos_t'(1);

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic pos_t span_to(input pos_t stop, input pos_t fs);
    return (stop >= fs) ? stop - fs : '0;
  endfunction

  function automatic ucs_res_t mk_res(input ucs_kind_e k, input pos_t st, input pos_t len,
                                      input logic [PORT_W-1:0] port, input logic okv,
                                      input logic fin);
    ucs_res_t r;
    r.kind      = k;
    r.start_pos = START_W'({{START_W{1'b0}}, st});
    r.span_len  = LEN_W'({{LEN_W{1'b0}}, len});
    r.port_num  = port;
    r.ok        = okv;
    r.final_res = fin;
    return r;
  endfunction

  ucs_mode_e         mode_q, mode_d;
  pos_t              pos_q, pos_d;
  pos_t              fs_q, fs_d;
  pos_t              hs_q, hs_d;
  pos_t              hl_q, hl_d;
  logic [PORT_W-1:0] acc_q, acc_d;
  logic              bad_q, bad_d;

  logic [19:0]       acc_prod;
  logic [PORT_W-1:0] acc_feed;
  logic              ch_digit;
  pos_t              endp;
  pos_t              plen;
  logic [PORT_W-1:0] pval;
  logic [CNT_W-1:0]  n;
  ucs_res_t          slot [MAX_RES];

  // Decimal accumulate with saturation: acc * 10 + digit
  assign ch_digit = is_numeral(ch_i);
  always_comb begin
    acc_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {16'b0, ch_i[3:0]};
    acc_feed = (acc_prod > 20'd65535) ? 16'hFFFF : acc_prod[15:0];
  end

  // Step: take one byte, then close open components on the last byte
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    fs_d   = fs_q;
    hs_d   = hs_q;
    hl_d   = hl_q;
    acc_d  = acc_q;
    bad_d  = bad_q;
    endp   = pos_q + PosOne;
    plen   = '0;
    pval   = '0;
    n      = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      slot[i] = '0;
    end

    if (step_i) begin
      if (pos_q >= PosMax) begin
        mode_d = ST_ERR;
      end else if ((pos_q == '0) && last_byte_i && (ch_i == CH_SLASH)) begin
        // lone slash is a one-byte path
        mode_d = ST_BEGIN;
      end else begin
        pos_d = pos_q + PosOne;
        unique case (mode_q)
          ST_BEGIN: begin
            if (ch_i == CH_DOT) begin
              fs_d = pos_q; mode_d = ST_PATH;
            end else if (ch_i == CH_SLASH) begin
              mode_d = ST_SL1;
            end else if (is_letter(ch_i)) begin
              fs_d = pos_q; mode_d = ST_SCHEME;
            end else begin
              mode_d = ST_ERR;
            end
          end
          ST_SCHEME: begin
            if (ch_i == CH_COLON) begin
              slot[n[1:0]] = mk_res(K_SCHEME, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              mode_d = ST_AFTER_COLON;
            end else if (!(is_letter(ch_i) || ch_digit || (ch_i == CH_PLUS) ||
                           (ch_i == CH_DOT) || (ch_i == CH_MINUS))) begin
              mode_d = ST_ERR;
            end
          end
          ST_AFTER_COLON: begin
            if (ch_i == CH_SLASH) begin
              mode_d = ST_SL1;
            end else begin
              fs_d = pos_q; mode_d = ST_PATH;
            end
          end
          ST_SL1: begin
            if (ch_i == CH_SLASH) begin
              mode_d = ST_SL2;
            end else begin
              fs_d = pos_q - PosOne; mode_d = ST_PATH;
            end
          end
          ST_SL2: begin
            if (ch_i == CH_SLASH) begin
              fs_d = pos_q; mode_d = ST_PATH;
            end else if (ch_i == CH_LBRACK) begin
              fs_d = pos_q; mode_d = ST_BOPEN;
            end else if ((ch_i == CH_AT) || (ch_i == CH_COLON)) begin
              mode_d = ST_ERR;
            end else begin
              fs_d = pos_q; mode_d = ST_UH;
            end
          end
          ST_UH: begin
            if (ch_i == CH_AT) begin
              slot[n[1:0]] = mk_res(K_USER, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              mode_d = ST_H1;
            end else if (ch_i == CH_COLON) begin
              // hold the text so far until '@', '/' or the end of the text tells what it was
              hs_d   = fs_d;
              hl_d   = span_to(pos_q, fs_d);
              fs_d   = pos_q + PosOne;
              acc_d  = '0;
              bad_d  = 1'b0;
              mode_d = ST_PP;
            end else if (ch_i == CH_SLASH) begin
              slot[n[1:0]] = mk_res(K_HOST, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q; mode_d = ST_PATH;
            end
          end
          ST_PP: begin
            if (ch_i == CH_AT) begin
              slot[n[1:0]] = mk_res(K_USER, hs_d, hl_d, '0, 1'b0, 1'b0);
              n = n + 3'd1;
              slot[n[1:0]] = mk_res(K_PWD, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              mode_d = ST_H1;
            end else if (ch_i == CH_SLASH) begin
              slot[n[1:0]] = mk_res(K_HOST, hs_d, hl_d, '0, 1'b0, 1'b0);
              n = n + 3'd1;
              plen = span_to(pos_q, fs_d);
              pval = (bad_d || (plen == '0)) ? '0 : acc_d;
              slot[n[1:0]] = mk_res(K_PORT, fs_d, plen, pval, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q; mode_d = ST_PATH;
            end else if (ch_digit) begin
              acc_d = acc_feed;
            end else begin
              bad_d = 1'b1;
            end
          end
          ST_H1: begin
            fs_d = pos_q;
            if (ch_i == CH_LBRACK) begin
              mode_d = ST_BOPEN;
            end else if (ch_i == CH_COLON) begin
              mode_d = ST_ERR;
            end else begin
              mode_d = ST_H2;
            end
          end
          ST_H2: begin
            if (ch_i == CH_COLON) begin
              slot[n[1:0]] = mk_res(K_HOST, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q + PosOne; acc_d = '0; bad_d = 1'b0; mode_d = ST_PORT;
            end else if (ch_i == CH_SLASH) begin
              slot[n[1:0]] = mk_res(K_HOST, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q; mode_d = ST_PATH;
            end
          end
          ST_BOPEN: begin
            mode_d = (ch_i == CH_RBRACK) ? ST_ERR : ST_V6;
          end
          ST_V6: begin
            if (ch_i == CH_RBRACK) begin
              mode_d = ST_BCLOSE;
            end
          end
          ST_BCLOSE: begin
            // bracketed host ends at ']', before this byte
            slot[n[1:0]] = mk_res(K_HOST, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
            n = n + 3'd1;
            if (ch_i == CH_COLON) begin
              fs_d = pos_q + PosOne; acc_d = '0; bad_d = 1'b0; mode_d = ST_PORT;
            end else if (ch_i == CH_SLASH) begin
              fs_d = pos_q; mode_d = ST_PATH;
            end else begin
              mode_d = ST_ERR;
            end
          end
          ST_PORT: begin
            if (ch_i == CH_SLASH) begin
              plen = span_to(pos_q, fs_d);
              pval = (bad_d || (plen == '0)) ? '0 : acc_d;
              slot[n[1:0]] = mk_res(K_PORT, fs_d, plen, pval, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q; mode_d = ST_PATH;
            end else if (!ch_digit) begin
              mode_d = ST_ERR;
            end else begin
              acc_d = acc_feed;
            end
          end
          ST_PATH: begin
            if ((ch_i == CH_QMARK) || (ch_i == CH_HASH)) begin
              slot[n[1:0]] = mk_res(K_PATH, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d   = pos_q + PosOne;
              mode_d = (ch_i == CH_QMARK) ? ST_QUERY : ST_FRAG;
            end
          end
          ST_QUERY: begin
            if (ch_i == CH_HASH) begin
              slot[n[1:0]] = mk_res(K_QUERY, fs_d, span_to(pos_q, fs_d), '0, 1'b0, 1'b0);
              n = n + 3'd1;
              fs_d = pos_q + PosOne; mode_d = ST_FRAG;
            end
          end
          default: begin
          end
        endcase
      end

      if ((pos_q < PosMax) && (pos_q == '0) && last_byte_i && (ch_i == CH_SLASH)) begin
        slot[0] = mk_res(K_PATH, '0, PosOne, '0, 1'b0, 1'b0);
        slot[1] = mk_res(K_DONE, '0, '0, '0, 1'b1, 1'b1);
        n = 3'd2;
      end else if (last_byte_i) begin
        // close whatever is open at the end of the text
        unique case (mode_d)
          ST_SCHEME, ST_AFTER_COLON, ST_SL1, ST_SL2: begin
            mode_d = ST_ERR;
          end
          ST_UH, ST_H2, ST_BCLOSE: begin
            slot[n[1:0]] = mk_res(K_HOST, fs_d, span_to(endp, fs_d), '0, 1'b0, 1'b0);
            n = n + 3'd1;
          end
          ST_PP, ST_PORT: begin
            if (mode_d == ST_PP) begin
              slot[n[1:0]] = mk_res(K_HOST, hs_d, hl_d, '0, 1'b0, 1'b0);
              n = n + 3'd1;
            end
            plen = span_to(endp, fs_d);
            pval = (bad_d || (plen == '0)) ? '0 : acc_d;
            slot[n[1:0]] = mk_res(K_PORT, fs_d, plen, pval, 1'b0, 1'b0);
            n = n + 3'd1;
          end
          ST_PATH: begin
            slot[n[1:0]] = mk_res(K_PATH, fs_d, span_to(endp, fs_d), '0, 1'b0, 1'b0);
            n = n + 3'd1;
          end
          ST_QUERY: begin
            slot[n[1:0]] = mk_res(K_QUERY, fs_d, span_to(endp, fs_d), '0, 1'b0, 1'b0);
            n = n + 3'd1;
          end
          ST_FRAG: begin
            slot[n[1:0]] = mk_res(K_FRAG, fs_d, span_to(endp, fs_d), '0, 1'b0, 1'b0);
            n = n + 3'd1;
          end
          default: begin
          end
        endcase
        slot[n[1:0]] = mk_res(K_DONE, '0, '0, '0, mode_d != ST_ERR, 1'b1);
        n = n + 3'd1;
      end

      // back to the start state for the next URL
      if (last_byte_i) begin
        mode_d = ST_BEGIN;
        pos_d  = '0;
        fs_d   = '0;
        hs_d   = '0;
        hl_d   = '0;
        acc_d  = '0;
        bad_d  = 1'b0;
      end
    end
  end

  // Pack the results for the queue
  always_comb begin
    batch_o.cnt = n;
    for (int i = 0; i < MAX_RES; i++) begin
      batch_o.res[i] = slot[i];
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ST_BEGIN;
      pos_q  <= '0;
      fs_q   <= '0;
      hs_q   <= '0;
      hl_q   <= '0;
      acc_q  <= '0;
      bad_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      fs_q   <= fs_d;
      hs_q   <= hs_d;
      hl_q   <= hl_d;
      acc_q  <= acc_d;
      bad_q  <= bad_d;
    end
  end

endmodule

@@ hdl/ucs_res_fifo.sv @@
// Result queue: takes up to four results a cycle, hands out one a cycle.
// Depends on ucs_pkg.
module ucs_res_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ucs_pkg::ucs_batch_t     batch_i,
  input  logic                    pop_i,
  output ucs_pkg::ucs_res_t       head_o,
  output ucs_pkg::ucs_fifo_stat_t stat_o
);
  import ucs_pkg::*;

  ucs_res_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]    wptr_q, rptr_q;
  logic [FILL_W-1:0]   fill_q;

  // Write the batch at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (CNT_W'(i) < batch_i.cnt) begin
        mem_q[wptr_q + PTR_W'(i)] <= batch_i.res[i];
      end
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_q + PTR_W'(batch_i.cnt);
      rptr_q <= rptr_q + PTR_W'(pop_i);
      fill_q <= fill_q + FILL_W'(batch_i.cnt) - FILL_W'(pop_i);
    end
  end

  assign head_o           = mem_q[rptr_q];
  assign stat_o.not_empty = (fill_q != '0);
  assign stat_o.room      = (fill_q <= FILL_W'(FIFO_DEPTH - MAX_RES));

endmodule
